@@ rtl/dlb_pkg.sv @@
// Shared types, constants and unorm16 arithmetic for the difference layer blend.
package dlb_pkg;

  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned NStg    = 18;
  localparam int unsigned NDiv    = 8;
  localparam int unsigned DivBits = 2;

  localparam logic [CfgIdxW-1:0] CfgOpacity = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgMaskEn  = CfgIdxW'(1);

  localparam logic [15:0] UnormOne  = 16'hFFFF;
  localparam logic [32:0] UnormHalf = 33'd32767;

  typedef logic [2:0][15:0] rgb_t;

  // Pixel as taken from the input channel
  typedef struct packed {
    rgb_t        base;
    rgb_t        lay;
    logic [15:0] in_a;
    logic [15:0] mask;
    logic        last;
  } pix_t;

  // Pixel as carried down the pipeline once the colour differences are known
  typedef struct packed {
    rgb_t        base;
    rgb_t        diff;
    logic [15:0] in_a;
    logic [15:0] mask;
    logic        last;
    logic        byp;
  } pass_t;

  typedef struct packed {
    logic en_mul;
    logic en_sum;
    logic en_out;
  } lane_ctl_t;

  // floor(x / 65535) for x below 65536 * 65535: estimate, then one correction
  function automatic logic [15:0] unorm_div(input logic [32:0] x);
    logic [33:0] t;
    logic [17:0] e;
    logic [33:0] rem;
    t   = {1'b0, x} + {17'b0, x[32:16]};
    e   = t[33:16];
    rem = {1'b0, x} - ({e, 16'b0} - {16'b0, e});
    if (rem >= 34'd65535) begin
      e = e + 18'd1;
    end
    return e[15:0];
  endfunction

  // Nearest integer to p / 65535
  function automatic logic [15:0] unorm_round(input logic [31:0] p);
    return unorm_div({1'b0, p} + UnormHalf);
  endfunction

endpackage

@@ rtl/dlb_ifs.sv @@
// Channel interfaces: pixel input, blended pixel output and register write port.
interface dlb_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] in_red;
  logic [15:0] in_green;
  logic [15:0] in_blue;
  logic [15:0] in_alpha;
  logic [15:0] layer_red;
  logic [15:0] layer_green;
  logic [15:0] layer_blue;
  logic [15:0] layer_alpha;
  logic [15:0] mask_value;
  logic        last_in;

  modport source (
    output valid, in_red, in_green, in_blue, in_alpha,
           layer_red, layer_green, layer_blue, layer_alpha, mask_value, last_in,
    input  ready
  );
  modport sink (
    input  valid, in_red, in_green, in_blue, in_alpha,
           layer_red, layer_green, layer_blue, layer_alpha, mask_value, last_in,
    output ready
  );
endinterface

interface dlb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_red;
  logic [15:0] out_green;
  logic [15:0] out_blue;
  logic [15:0] out_alpha;
  logic        last_out;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha, last_out,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha, last_out,
    output ready
  );
endinterface

interface dlb_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/difference_layer_blend.sv @@
// Difference layer blend with alpha compositing on unorm16 RGBA pixels.
//
//   port      dir   carries
//   in_pix    sink  base RGBA, layer RGBA, mask weight, last mark
//   out_pix   src   blended RGB, base alpha, last mark
//   cfg_wr    sink  register index and write data, always ready
//
// One pixel per clock while out_pix is ready; 18 register stages from input
// transfer to output register. The ratio comes from a pipelined restoring
// divider of eight stages, two quotient bits each. A stage takes a new pixel
// when out_pix is ready or when it or any stage downstream holds a bubble, so
// bubbles collapse during a stall. Synchronous active-low reset clears the
// valid bits and the configuration registers.
module difference_layer_blend
  import dlb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  dlb_in_if.sink     in_pix,
  dlb_out_if.source  out_pix,
  dlb_cfg_if.sink    cfg_wr
);

  localparam int unsigned StMulOp   = 0;
  localparam int unsigned StRndOp   = 1;
  localparam int unsigned StMulMask = 2;
  localparam int unsigned StRndMask = 3;
  localparam int unsigned StMulNa   = 4;
  localparam int unsigned StRndNa   = 5;
  localparam int unsigned StNa      = 6;
  localparam int unsigned StBlMul   = StNa + NDiv + 1;
  localparam int unsigned StBlSum   = StBlMul + 1;
  localparam int unsigned StOut     = StBlSum + 1;

  // Configuration registers
  logic [15:0] opacity_r;
  logic        mask_en_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opacity_r <= UnormOne;
      mask_en_r <= 1'b0;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        CfgOpacity: opacity_r <= cfg_wr.data;
        CfgMaskEn:  mask_en_r <= cfg_wr.data[0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and load enables
  logic [NStg-1:0] v_r;
  logic [NStg-1:0] load;

  always_comb begin
    for (int k = 0; k < NStg; k++) begin
      load[k] = out_pix.ready || (((~v_r) >> k) != '0);
    end
  end

  assign in_pix.ready = load[StMulOp];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (load[0]) begin
        v_r[0] <= in_pix.valid;
      end
      for (int k = 1; k < NStg; k++) begin
        if (load[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Payload registers
  pix_t        pix0_r;
  logic [31:0] prod_op_r;
  pass_t       pass_r [1:NStg-1];
  logic [15:0] ca1_r;
  logic [31:0] prod_mask_r;
  logic [15:0] ca3_r;
  logic [15:0] ca4_r;
  logic [15:0] ca5_r;
  logic [31:0] prod_na_r;
  logic [15:0] rn_r;

  logic [15:0] drem_r [NDiv+1];
  logic [15:0] dlo_r  [NDiv+1];
  logic [15:0] dq_r   [NDiv+1];
  logic [15:0] dna_r  [NDiv+1];
  logic [15:0] drem_nxt [NDiv];
  logic [15:0] dlo_nxt  [NDiv];
  logic [15:0] dq_nxt   [NDiv];

  pix_t        pix_in;
  logic [15:0] alpha_min;
  pass_t       pass1_nxt;
  pass_t       pass6_nxt;
  logic [15:0] na_nxt;
  logic [31:0] dividend;

  always_comb begin
    pix_in.base = {in_pix.in_blue, in_pix.in_green, in_pix.in_red};
    pix_in.lay  = {in_pix.layer_blue, in_pix.layer_green, in_pix.layer_red};
    pix_in.in_a = in_pix.in_alpha;
    pix_in.mask = in_pix.mask_value;
    pix_in.last = in_pix.last_in;
    alpha_min   = (in_pix.in_alpha < in_pix.layer_alpha) ? in_pix.in_alpha
                                                          : in_pix.layer_alpha;
  end

  always_comb begin
    pass1_nxt.base = pix0_r.base;
    pass1_nxt.in_a = pix0_r.in_a;
    pass1_nxt.mask = pix0_r.mask;
    pass1_nxt.last = pix0_r.last;
    pass1_nxt.byp  = 1'b0;
    for (int c = 0; c < 3; c++) begin
      pass1_nxt.diff[c] = (pix0_r.base[c] > pix0_r.lay[c]) ?
                          (pix0_r.base[c] - pix0_r.lay[c]) :
                          (pix0_r.lay[c] - pix0_r.base[c]);
    end
  end

  assign na_nxt   = 16'({1'b0, pass_r[StRndNa].in_a} + {1'b0, rn_r});
  assign dividend = {ca5_r, 16'b0} - {16'b0, ca5_r};

  // Zero effective alpha: mark the pixel for pass-through
  always_comb begin
    pass6_nxt     = pass_r[StRndNa];
    pass6_nxt.byp = (ca5_r == '0) || (na_nxt == '0);
  end

  // Restoring division, DivBits quotient bits per stage
  always_comb begin
    logic [15:0] r;
    logic [15:0] lo;
    logic [15:0] q;
    logic [16:0] t;
    for (int j = 0; j < NDiv; j++) begin
      r  = drem_r[j];
      lo = dlo_r[j];
      q  = dq_r[j];
      for (int s = 0; s < DivBits; s++) begin
        t  = {r, lo[15]};
        lo = {lo[14:0], 1'b0};
        if (t >= {1'b0, dna_r[j]}) begin
          t = t - {1'b0, dna_r[j]};
          q = {q[14:0], 1'b1};
        end else begin
          q = {q[14:0], 1'b0};
        end
        r = t[15:0];
      end
      drem_nxt[j] = r;
      dlo_nxt[j]  = lo;
      dq_nxt[j]   = q;
    end
  end

  always_ff @(posedge clk) begin
    if (load[StMulOp]) begin
      pix0_r    <= pix_in;
      prod_op_r <= 32'(alpha_min) * 32'(opacity_r);
    end
    if (load[StRndOp]) begin
      pass_r[StRndOp] <= pass1_nxt;
      ca1_r           <= unorm_round(prod_op_r);
    end
    if (load[StMulMask]) begin
      // without a mask, scale by one: rounding then gives ca back unchanged
      prod_mask_r <= 32'(ca1_r) *
                     32'(mask_en_r ? pass_r[StRndOp].mask : UnormOne);
    end
    if (load[StRndMask]) begin
      ca3_r <= unorm_round(prod_mask_r);
    end
    if (load[StMulNa]) begin
      ca4_r     <= ca3_r;
      prod_na_r <= 32'(UnormOne - pass_r[StRndMask].in_a) * 32'(ca3_r);
    end
    if (load[StRndNa]) begin
      ca5_r <= ca4_r;
      rn_r  <= unorm_round(prod_na_r);
    end
    if (load[StNa]) begin
      drem_r[0] <= dividend[31:16];
      dlo_r[0]  <= dividend[15:0];
      dq_r[0]   <= '0;
      dna_r[0]  <= na_nxt;
    end
    for (int j = 0; j < NDiv; j++) begin
      if (load[StNa + 1 + j]) begin
        drem_r[j+1] <= drem_nxt[j];
        dlo_r[j+1]  <= dlo_nxt[j];
        dq_r[j+1]   <= dq_nxt[j];
        dna_r[j+1]  <= dna_r[j];
      end
    end
    for (int k = StMulMask; k < NStg; k++) begin
      if (load[k]) begin
        pass_r[k] <= (k == StNa) ? pass6_nxt : pass_r[k-1];
      end
    end
  end

  // Colour lanes
  lane_ctl_t   lane_ctl;
  logic [15:0] lane_res [3];

  assign lane_ctl.en_mul = load[StBlMul];
  assign lane_ctl.en_sum = load[StBlSum];
  assign lane_ctl.en_out = load[StOut];

  for (genvar c = 0; c < 3; c++) begin : g_lane
    dlb_blend_lane u_lane (
      .clk    (clk),
      .ctl    (lane_ctl),
      .base   (pass_r[StBlMul-1].base[c]),
      .diff   (pass_r[StBlMul-1].diff[c]),
      .ratio  (dq_r[NDiv]),
      .byp    (pass_r[StBlMul-1].byp),
      .result (lane_res[c])
    );
  end

  assign out_pix.valid     = v_r[StOut];
  assign out_pix.out_red   = lane_res[0];
  assign out_pix.out_green = lane_res[1];
  assign out_pix.out_blue  = lane_res[2];
  assign out_pix.out_alpha = pass_r[StOut].in_a;
  assign out_pix.last_out  = pass_r[StOut].last;

endmodule

@@ rtl/dlb_blend_lane.sv @@
// One colour lane: weighted sum of difference and base, rounded to unorm16.
module dlb_blend_lane
  import dlb_pkg::*;
(
  input  logic        clk,
  input  lane_ctl_t   ctl,
  input  logic [15:0] base,
  input  logic [15:0] diff,
  input  logic [15:0] ratio,
  input  logic        byp,
  output logic [15:0] result
);

  logic [31:0] prod_a_r;
  logic [31:0] prod_b_r;
  logic [15:0] base_a_r;
  logic        byp_a_r;
  logic [32:0] sum_r;
  logic [15:0] base_b_r;
  logic        byp_b_r;
  logic [15:0] result_r;

  always_ff @(posedge clk) begin
    if (ctl.en_mul) begin
      prod_a_r <= 32'(diff) * 32'(ratio);
      prod_b_r <= 32'(base) * 32'(UnormOne - ratio);
      base_a_r <= base;
      byp_a_r  <= byp;
    end
    if (ctl.en_sum) begin
      sum_r    <= {1'b0, prod_a_r} + {1'b0, prod_b_r} + UnormHalf;
      base_b_r <= base_a_r;
      byp_b_r  <= byp_a_r;
    end
    if (ctl.en_out) begin
      // zero effective alpha: pass the base colour through
      result_r <= byp_b_r ? base_b_r : unorm_div(sum_r);
    end
  end

  assign result = result_r;

endmodule
